@@ hdl/nbsc_pkg.sv @@
// Shared types, constants and helper functions for the nested bundle stream checker.
// Used by nbsc_step and nested_bundle_stream_checker_core; depends on nothing else.
package nbsc_pkg;

	// Number of little-endian bytes in a payload length field.
	localparam int LENGTH_BYTES = 4;
	// Width of the entry counter before the 16-bit output cap.
	localparam int COUNT_BITS   = 16;

	localparam int LEN_W = 8 * LENGTH_BYTES;
	localparam int CNT_W = (COUNT_BITS >= 16) ? 16 : COUNT_BITS;

	localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
	localparam logic [31:0]      MAGIC_RESET = 32'h3142_4245;
	localparam logic [3:0]       DEPTH_RESET = 4'd4;
	localparam logic [3:0]       DEPTH_CAP   = 4'd14;
	localparam logic [3:0]       TOP_LEVEL   = 4'd1;
	localparam logic [7:0]       LEN_LAST    = 8'(LENGTH_BYTES - 1);

	localparam logic [7:0] KIND_PLAIN_LO = 8'd1;
	localparam logic [7:0] KIND_PLAIN_HI = 8'd3;
	localparam logic [7:0] KIND_OPEN     = 8'd4;
	localparam logic [7:0] KIND_CLOSE    = 8'd5;

	// Configuration register indexes.
	localparam logic CFG_MAGIC = 1'b0;
	localparam logic CFG_DEPTH = 1'b1;

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_KIND,
		PH_NLEN,
		PH_NAME,
		PH_LEN,
		PH_PAY,
		PH_IGNORE
	} phase_t;

	typedef enum logic [2:0] {
		ROLE_MAGIC,
		ROLE_KIND,
		ROLE_CLOSE,
		ROLE_NLEN,
		ROLE_NAME,
		ROLE_LEN,
		ROLE_PAY,
		ROLE_IGNORED
	} role_t;

	typedef enum logic [2:0] {
		FAULT_NONE,
		FAULT_MAGIC,
		FAULT_TRUNC,
		FAULT_KIND,
		FAULT_DEEP
	} fault_t;

	typedef struct packed {
		phase_t             phase;
		logic [1:0]         magic_pos;
		logic [23:0]        magic_acc;
		logic [3:0]         depth;
		logic [7:0]         kind;
		logic [LEN_W-1:0]   remaining;
		logic [LEN_W-1:0]   len_acc;
		logic [7:0]         field_pos;
		logic [CNT_W-1:0]   count;
		fault_t             fault;
		logic               finished;
	} parse_state_t;

	typedef struct packed {
		role_t       role;
		logic [7:0]  kind;
		logic [3:0]  level;
		logic [7:0]  name_index;
		logic        done;
		logic        verdict_valid;
		logic        good;
		fault_t      fault;
		logic [15:0] count;
	} result_t;

	// Parser state at the start of every bundle.
	function automatic parse_state_t bundle_clear();
		parse_state_t s;
		s.phase     = PH_MAGIC;
		s.magic_pos = '0;
		s.magic_acc = '0;
		s.depth     = TOP_LEVEL;
		s.kind      = '0;
		s.remaining = '0;
		s.len_acc   = '0;
		s.field_pos = '0;
		s.count     = '0;
		s.fault     = FAULT_NONE;
		s.finished  = 1'b0;
		return s;
	endfunction

endpackage

@@ hdl/nested_bundle_stream_checker_core.sv @@
// Top level of the nested bundle stream checker: input register, parser state,
// configuration registers and result register. Depends on nbsc_pkg and nbsc_step.
//
// Usage: the bundle stream enters one byte per transfer on the input channel
// (data_byte, last_byte with in_valid / in_stall). Each accepted byte yields
// exactly one result transfer on the output channel (out_valid / out_stall)
// that tells the role of the byte, the entry kind, the nesting level, the
// position inside a name or length field, entry completion and entry count,
// and on the last byte or the top-level close mark the verdict and fault.
// An accepted byte waits in the input register and is parsed when it moves
// from there into the result register, which happens once the result
// register is free. The parser update is a single step of short logic
// against the held state, so one byte is taken in every cycle unless the
// output stalls, and without stalls the throughput is one byte per cycle.
// When the receiver stalls, the result register holds its value and the
// input register fills; in_stall rises only while both are occupied and the
// output is stalled, so no byte is lost or repeated.
// Configuration writes (index 0 magic word, index 1 depth limit) are always
// ready and should be issued only while no byte is in flight.
// Reset clears both channels, returns the parser to the magic phase and
// loads the default magic word and depth limit.
module nested_bundle_stream_checker_core (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  byte_role,
	output logic [7:0]  entry_kind,
	output logic [3:0]  nesting_level,
	output logic [7:0]  name_index,
	output logic        entry_done,
	output logic        verdict_valid,
	output logic        bundle_good,
	output logic [2:0]  fault_code,
	output logic [15:0] entry_count,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import nbsc_pkg::*;

	// Input register stage.
	logic         valid_s1;
	logic [7:0]   data_s1;
	logic         last_s1;

	// Parser state and configuration.
	parse_state_t state_q;
	parse_state_t state_next;
	logic [31:0]  magic_word_q;
	logic [3:0]   depth_limit_q;

	// Result register.
	logic         out_valid_q;
	result_t      result_q;
	result_t      result_next;

	logic         out_free;
	logic         advance;

	// The result register can take a new result when it is empty or when its
	// current result is being transferred out in this cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	nbsc_step u_step (
		.st          (state_q),
		.data_byte   (data_s1),
		.last_byte   (last_s1),
		.magic_word  (magic_word_q),
		.depth_limit (depth_limit_q),
		.st_next     (state_next),
		.res         (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= bundle_clear();
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (advance) begin
				state_q <= state_next;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
		if (advance) begin
			result_q <= result_next;
		end
	end

	// Configuration registers; the write channel never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q  <= MAGIC_RESET;
			depth_limit_q <= DEPTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAGIC: magic_word_q  <= cfg_data;
				CFG_DEPTH: depth_limit_q <= cfg_data[3:0];
				default:   magic_word_q  <= magic_word_q;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign byte_role     = result_q.role;
	assign entry_kind    = result_q.kind;
	assign nesting_level = result_q.level;
	assign name_index    = result_q.name_index;
	assign entry_done    = result_q.done;
	assign verdict_valid = result_q.verdict_valid;
	assign bundle_good   = result_q.good;
	assign fault_code    = result_q.fault;
	assign entry_count   = result_q.count;

endmodule

@@ hdl/nbsc_step.sv @@
// Next-state and per-byte result logic of the nested bundle stream checker.
// Purely combinational; depends on nbsc_pkg.
module nbsc_step (
	input  nbsc_pkg::parse_state_t st,
	input  logic [7:0]             data_byte,
	input  logic                   last_byte,
	input  logic [31:0]            magic_word,
	input  logic [3:0]             depth_limit,
	output nbsc_pkg::parse_state_t st_next,
	output nbsc_pkg::result_t      res
);
	import nbsc_pkg::*;

	// Entry head (kind, name length, name) is complete: open a list, go on
	// to the length field, or fault.
	function automatic parse_state_t head_done(parse_state_t s, logic [3:0] lim);
		parse_state_t t;
		t = s;
		if (s.kind == KIND_OPEN) begin
			if (s.depth > lim) begin
				t.fault = FAULT_DEEP;
				t.phase = PH_IGNORE;
			end else begin
				t.depth = s.depth + 4'd1;
				t.phase = PH_KIND;
			end
		end else if (s.kind inside {[KIND_PLAIN_LO:KIND_PLAIN_HI]}) begin
			t.phase     = PH_LEN;
			t.field_pos = '0;
			t.len_acc   = '0;
		end else begin
			t.fault = FAULT_KIND;
			t.phase = PH_IGNORE;
		end
		return t;
	endfunction

	function automatic logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] c);
		return (c != CNT_MAX) ? c + 1'b1 : c;
	endfunction

	logic [3:0]       lim;
	logic [LEN_W-1:0] len_full;
	logic [LEN_W-1:0] rem_dec;
	parse_state_t     nx;

	assign lim      = (depth_limit > DEPTH_CAP) ? DEPTH_CAP : depth_limit;
	assign len_full = st.len_acc | (LEN_W'(data_byte) << {st.field_pos[2:0], 3'b000});
	assign rem_dec  = st.remaining - 1'b1;

	always_comb begin
		nx                = st;
		res.role          = ROLE_IGNORED;
		res.kind          = '0;
		res.name_index    = '0;
		res.done          = 1'b0;
		res.verdict_valid = 1'b0;
		res.good          = 1'b0;

		case (st.phase)
			PH_MAGIC: begin
				res.role = ROLE_MAGIC;
				if (st.magic_pos == 2'd3) begin
					nx.magic_pos = '0;
					nx.magic_acc = '0;
					if ({data_byte, st.magic_acc} != magic_word) begin
						nx.fault = FAULT_MAGIC;
						nx.phase = PH_IGNORE;
					end else begin
						nx.phase = PH_KIND;
					end
				end else begin
					nx.magic_pos = st.magic_pos + 2'd1;
					nx.magic_acc = {data_byte, st.magic_acc[23:8]};
				end
			end
			PH_KIND: begin
				nx.kind  = data_byte;
				res.kind = data_byte;
				if (data_byte == KIND_CLOSE) begin
					res.role = ROLE_CLOSE;
					if (st.depth > TOP_LEVEL) begin
						nx.depth = st.depth - 4'd1;
						nx.count = count_up(st.count);
						res.done = 1'b1;
					end else begin
						nx.finished       = 1'b1;
						nx.phase          = PH_IGNORE;
						res.verdict_valid = 1'b1;
						res.good          = 1'b1;
					end
				end else begin
					res.role = ROLE_KIND;
					nx.phase = PH_NLEN;
				end
			end
			PH_NLEN: begin
				res.role     = ROLE_NLEN;
				res.kind     = st.kind;
				nx.remaining = LEN_W'(data_byte);
				nx.field_pos = '0;
				if (data_byte == 8'd0) begin
					nx = head_done(nx, lim);
				end else begin
					nx.phase = PH_NAME;
				end
			end
			PH_NAME: begin
				res.role       = ROLE_NAME;
				res.kind       = st.kind;
				res.name_index = st.field_pos;
				nx.field_pos   = st.field_pos + 8'd1;
				nx.remaining   = rem_dec;
				if (rem_dec == '0) begin
					nx = head_done(nx, lim);
				end
			end
			PH_LEN: begin
				res.role       = ROLE_LEN;
				res.kind       = st.kind;
				res.name_index = st.field_pos;
				nx.len_acc     = len_full;
				nx.field_pos   = st.field_pos + 8'd1;
				if (st.field_pos == LEN_LAST) begin
					nx.remaining = len_full;
					if (len_full == '0) begin
						nx.count = count_up(st.count);
						res.done = 1'b1;
						nx.phase = PH_KIND;
					end else begin
						nx.phase = PH_PAY;
					end
				end
			end
			PH_PAY: begin
				res.role     = ROLE_PAY;
				res.kind     = st.kind;
				nx.remaining = rem_dec;
				if (rem_dec == '0) begin
					nx.count = count_up(st.count);
					res.done = 1'b1;
					nx.phase = PH_KIND;
				end
			end
			default: begin
				res.role = ROLE_IGNORED;
			end
		endcase

		// The last byte always carries a verdict; an unfinished bundle is
		// reported as its earlier fault, or else as short magic or truncated.
		if (last_byte) begin
			res.verdict_valid = 1'b1;
			if (nx.finished) begin
				res.good = 1'b1;
			end else if (nx.fault == FAULT_NONE) begin
				if (nx.phase == PH_KIND && nx.depth == TOP_LEVEL) begin
					res.good = 1'b1;
				end else begin
					nx.fault = (nx.phase == PH_MAGIC) ? FAULT_MAGIC : FAULT_TRUNC;
				end
			end
			if (nx.fault != FAULT_NONE) begin
				res.good = 1'b0;
			end
		end

		res.level = nx.depth;
		res.fault = nx.fault;
		res.count = 16'(nx.count);

		st_next = last_byte ? bundle_clear() : nx;
	end

endmodule
